### design/integer_alu_execute_core_defines.svh
// Shared assertion macros for the integer execute core
`ifndef INTEGER_ALU_EXECUTE_CORE_DEFINES_SVH
`define INTEGER_ALU_EXECUTE_CORE_DEFINES_SVH

// same-cycle implication
`define IAE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iae assertion failed");

// next-cycle implication
`define IAE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iae assertion failed");

`endif

### design/iae_pkg.sv
package iae_pkg;

    localparam int REGISTER_COUNT = 64;
    localparam int RF_AW          = $clog2(REGISTER_COUNT);
    localparam logic [5:0] PRODUCT_INDEX  = 6'd62;
    localparam logic [5:0] QUOTIENT_INDEX = 6'd63;

    // operation codes
    localparam logic [4:0] K_NOP   = 5'd0;
    localparam logic [4:0] K_ADD   = 5'd1;
    localparam logic [4:0] K_SUB   = 5'd2;
    localparam logic [4:0] K_XOR   = 5'd3;
    localparam logic [4:0] K_OR    = 5'd4;
    localparam logic [4:0] K_AND   = 5'd5;
    localparam logic [4:0] K_LSL   = 5'd6;
    localparam logic [4:0] K_LSR   = 5'd7;
    localparam logic [4:0] K_ASR   = 5'd8;
    localparam logic [4:0] K_MUL   = 5'd9;
    localparam logic [4:0] K_DIVS  = 5'd10;
    localparam logic [4:0] K_DIVU  = 5'd11;
    localparam logic [4:0] K_REMS  = 5'd12;
    localparam logic [4:0] K_REMU  = 5'd13;
    localparam logic [4:0] K_BOOL  = 5'd14;
    localparam logic [4:0] K_SEXT  = 5'd15;
    localparam logic [4:0] K_SLTS  = 5'd16;
    localparam logic [4:0] K_SLTU  = 5'd17;
    localparam logic [4:0] K_SMOVE = 5'd18;
    localparam logic [4:0] K_MOVE  = 5'd19;
    localparam logic [4:0] K_SREAD = 5'd20;
    localparam logic [4:0] K_SWRT  = 5'd21;
    localparam logic [4:0] K_FCLR  = 5'd22;
    localparam logic [4:0] K_CMP   = 5'd23;
    localparam logic [4:0] K_END   = 5'd24;

    // special register selects
    localparam logic [1:0] SP_LINK   = 2'd0;
    localparam logic [1:0] SP_BRANCH = 2'd1;
    localparam logic [1:0] SP_FLAGS  = 2'd2;

    // multiply partial product phases
    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_LH = 2'd1;
    localparam logic [1:0] MUL_HL = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_phase;
        logic       div_init;
        logic       div_step;
        logic       commit;
    } iae_cmd_t;

    typedef struct packed {
        logic is_mul;
        logic is_div;
    } iae_status_t;

endpackage

### design/iae_ram.sv
module iae_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/iae_ctrl.sv
`include "integer_alu_execute_core_defines.svh"

module iae_ctrl
    import iae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  iae_status_t status,
    output iae_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_MUL2   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    // state sequencing and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.is_mul)
                begin
                    cmd.mul_en    = 1'b1;
                    cmd.mul_phase = MUL_LL;
                    state_next    = S_MUL1;
                end
                else if (status.is_div)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_MUL1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LH;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_HL;
                state_next    = S_COMMIT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    `IAE_ASSERT_NOW(a_busy_while_out, out_valid, in_stall)
    `IAE_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_reg == S_EXEC)
    `IAE_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid)
    `IAE_ASSERT_NEXT(a_div_done, state_reg == S_DIV && cnt_reg == 6'd63,
        state_reg == S_COMMIT)

endmodule

### design/iae_dp.sv
module iae_dp
    import iae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iae_cmd_t    cmd,
    output iae_status_t status,
    input  logic [4:0]  kind,
    input  logic [5:0]  dest_index,
    input  logic [63:0] operand_b,
    input  logic [63:0] operand_c,
    input  logic [1:0]  size,
    input  logic [1:0]  special_select,
    output logic [5:0]  written_index,
    output logic [63:0] written_value,
    output logic        wrote,
    output logic [2:0]  flag_bits,
    output logic        illegal,
    output logic        end_of_code
);

    // latched beat
    logic [4:0]  kind_reg;
    logic [5:0]  dest_reg;
    logic [63:0] b_reg, c_reg;
    logic [1:0]  size_reg, sel_reg;
    logic        rd_ok_reg;

    // architectural specials
    logic [63:0] link_reg, link_next;
    logic [63:0] branch_reg, branch_next;
    logic [63:0] flag_reg, flag_next;
    logic [REGISTER_COUNT-1:0] valid_reg;

    // multiply and divide
    logic [63:0] acc_reg, quo_reg, rem_reg, den_reg;
    logic        nb_reg, nc_reg;

    // output registers
    logic [5:0]  oidx_reg;
    logic [63:0] oval_reg;
    logic        owrote_reg, oill_reg, oend_reg;

    logic [63:0] rf_rdata, rd_val;
    logic        in_range_rd;

    assign in_range_rd = ({1'b0, dest_index} < 7'(REGISTER_COUNT));

    // register file
    logic             rf_we;
    logic [5:0]       wr_idx;
    logic [63:0]      wr_val;
    iae_ram #(.WIDTH(64), .DEPTH(REGISTER_COUNT)) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .waddr (wr_idx[RF_AW-1:0]),
        .wdata (wr_val),
        .re    (cmd.load),
        .raddr (dest_index[RF_AW-1:0]),
        .rdata (rf_rdata)
    );

    assign rd_val = rd_ok_reg ? rf_rdata : 64'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            dest_reg  <= dest_index;
            b_reg     <= operand_b;
            c_reg     <= operand_c;
            size_reg  <= size;
            sel_reg   <= special_select;
            rd_ok_reg <= in_range_rd && valid_reg[dest_index[RF_AW-1:0]];
        end
    end

    assign status.is_mul = (kind_reg == K_MUL);
    assign status.is_div = (kind_reg inside {K_DIVS, K_DIVU, K_REMS, K_REMU});

    // multiply: one 32x32 unit over three partial products
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    always_comb
    begin
        case (cmd.mul_phase)
            MUL_LL:  begin mul_a = b_reg[31:0];  mul_b = c_reg[31:0];  end
            MUL_LH:  begin mul_a = b_reg[31:0];  mul_b = c_reg[63:32]; end
            default: begin mul_a = b_reg[63:32]; mul_b = c_reg[31:0];  end
        endcase
    end
    assign prod = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            if (cmd.mul_phase == MUL_LL)
            begin
                acc_reg <= prod;
            end
            else
            begin
                acc_reg <= acc_reg + {prod[31:0], 32'd0};
            end
        end
    end

    // restoring divider on magnitudes, one bit per cycle
    logic        sgn_div, nb, nc;
    logic [64:0] trial;
    assign sgn_div = (kind_reg == K_DIVS) || (kind_reg == K_REMS);
    assign nb      = sgn_div && b_reg[63];
    assign nc      = sgn_div && c_reg[63];
    assign trial   = {rem_reg, quo_reg[63]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            quo_reg <= nb ? (64'd0 - b_reg) : b_reg;
            den_reg <= nc ? (64'd0 - c_reg) : c_reg;
            rem_reg <= '0;
            nb_reg  <= nb;
            nc_reg  <= nc;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= 64'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    // size mask and sign bit
    logic [63:0] mask;
    logic        sbit;
    always_comb
    begin
        case (size_reg)
            2'd0:    begin mask = 64'h0000_0000_0000_00FF; sbit = b_reg[7];  end
            2'd1:    begin mask = 64'h0000_0000_0000_FFFF; sbit = b_reg[15]; end
            2'd2:    begin mask = 64'h0000_0000_FFFF_FFFF; sbit = b_reg[31]; end
            default: begin mask = '1;                      sbit = 1'b0;      end
        endcase
    end

    logic [63:0] smove_sh;
    always_comb
    begin
        case (size_reg)
            2'd0:    smove_sh = b_reg;
            2'd1:    smove_sh = {b_reg[47:0], 16'd0};
            2'd2:    smove_sh = {b_reg[31:0], 32'd0};
            default: smove_sh = {b_reg[15:0], 48'd0};
        endcase
    end

    logic [63:0] special_val;
    always_comb
    begin
        case (sel_reg)
            SP_LINK:   special_val = link_reg;
            SP_BRANCH: special_val = branch_reg;
            default:   special_val = flag_reg;
        endcase
    end

    // result select and state update
    logic [5:0]  amt;
    logic [63:0] val, keep, a_m, b_m;
    logic        do_wr, wr_ok;
    assign amt = c_reg[5:0];
    assign a_m = rd_val & mask;
    assign b_m = b_reg & mask;

    always_comb
    begin
        val         = '0;
        do_wr       = 1'b0;
        wr_idx      = dest_reg;
        keep        = mask;
        link_next   = link_reg;
        branch_next = branch_reg;
        flag_next   = flag_reg;
        case (kind_reg)
            K_NOP, K_END: ;
            K_ADD:  begin val = b_reg + c_reg; do_wr = 1'b1; end
            K_SUB:  begin val = b_reg - c_reg; do_wr = 1'b1; end
            K_XOR:  begin val = b_reg ^ c_reg; do_wr = 1'b1; end
            K_OR:   begin val = b_reg | c_reg; do_wr = 1'b1; end
            K_AND:  begin val = b_reg & c_reg; do_wr = 1'b1; end
            K_LSL:  begin val = b_reg << amt;  do_wr = 1'b1; end
            K_LSR:  begin val = b_reg >> amt;  do_wr = 1'b1; end
            K_ASR:  begin val = 64'($signed(b_reg) >>> amt); do_wr = 1'b1; end
            K_MUL:  begin val = acc_reg; wr_idx = PRODUCT_INDEX; do_wr = 1'b1; end
            K_DIVS:
            begin
                wr_idx = QUOTIENT_INDEX; do_wr = 1'b1;
                if (c_reg == 64'd0)
                    val = '1;
                else
                    val = (nb_reg ^ nc_reg) ? (64'd0 - quo_reg) : quo_reg;
            end
            K_DIVU:
            begin
                wr_idx = QUOTIENT_INDEX; do_wr = 1'b1;
                val    = (c_reg == 64'd0) ? '1 : quo_reg;
            end
            K_REMS:
            begin
                wr_idx = QUOTIENT_INDEX; do_wr = 1'b1;
                if (c_reg == 64'd0)
                    val = b_reg;
                else
                    val = nb_reg ? (64'd0 - rem_reg) : rem_reg;
            end
            K_REMU:
            begin
                wr_idx = QUOTIENT_INDEX; do_wr = 1'b1;
                val    = (c_reg == 64'd0) ? b_reg : rem_reg;
            end
            K_BOOL: begin val = {63'd0, (b_m != 64'd0)}; do_wr = 1'b1; end
            K_SEXT: begin val = sbit ? (b_reg | ~mask) : b_reg; do_wr = 1'b1; end
            K_SLTS: begin val = {63'd0, ($signed(b_reg) < $signed(c_reg))}; do_wr = 1'b1; end
            K_SLTU: begin val = {63'd0, (b_reg < c_reg)}; do_wr = 1'b1; end
            K_SMOVE: begin val = rd_val | smove_sh; keep = '1; do_wr = 1'b1; end
            K_MOVE:  begin val = b_reg; keep = '1; do_wr = 1'b1; end
            K_SREAD:
            begin
                keep  = '1;
                val   = special_val;
                do_wr = (sel_reg inside {SP_LINK, SP_BRANCH, SP_FLAGS});
            end
            K_SWRT:
            begin
                case (sel_reg)
                    SP_LINK:   link_next   = rd_val;
                    SP_BRANCH: branch_next = rd_val;
                    SP_FLAGS:  flag_next   = rd_val;
                    default: ;
                endcase
            end
            K_FCLR: flag_next = {flag_reg[63:3], 3'd0};
            K_CMP:
            begin
                flag_next = {flag_reg[63:3], (b_m < a_m),
                             ($signed(b_m) < $signed(a_m)), (b_m != a_m)};
            end
            default: ;
        endcase
    end

    assign wr_ok  = do_wr && ({1'b0, wr_idx} < 7'(REGISTER_COUNT));
    assign wr_val = val & keep;
    assign rf_we  = cmd.commit && wr_ok;

    // specials and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg   <= '0;
            branch_reg <= '0;
            flag_reg   <= '0;
            valid_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            link_reg   <= link_next;
            branch_reg <= branch_next;
            flag_reg   <= flag_next;
            if (wr_ok)
            begin
                valid_reg[wr_idx[RF_AW-1:0]] <= 1'b1;
            end
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            oidx_reg   <= wr_ok ? wr_idx : 6'd0;
            oval_reg   <= wr_ok ? wr_val : 64'd0;
            owrote_reg <= wr_ok;
            oill_reg   <= (kind_reg > K_END);
            oend_reg   <= (kind_reg == K_END);
        end
    end

    assign written_index = oidx_reg;
    assign written_value = oval_reg;
    assign wrote         = owrote_reg;
    assign flag_bits     = flag_reg[2:0];
    assign illegal       = oill_reg;
    assign end_of_code   = oend_reg;

endmodule

### design/integer_alu_execute_core.sv
// Sequence: plain ops commit directly after accept; multiply first accumulates three
// 32x32 partial products, and divide and remainder first run the 64-step divider.
// Throughput: one beat in flight; next accept the cycle after the result is taken.
// Reset: rst_n async low clears the controller, special registers and the register
// file valid bits, so every general register reads as zero until written.
module integer_alu_execute_core
    import iae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  kind,
    input  logic [5:0]  dest_index,
    input  logic [63:0] operand_b,
    input  logic [63:0] operand_c,
    input  logic [1:0]  size,
    input  logic [1:0]  special_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  written_index,
    output logic [63:0] written_value,
    output logic        wrote,
    output logic [2:0]  flag_bits,
    output logic        illegal,
    output logic        end_of_code
);

    iae_cmd_t    cmd;
    iae_status_t status;

    iae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    iae_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .dest_index     (dest_index),
        .operand_b      (operand_b),
        .operand_c      (operand_c),
        .size           (size),
        .special_select (special_select),
        .written_index  (written_index),
        .written_value  (written_value),
        .wrote          (wrote),
        .flag_bits      (flag_bits),
        .illegal        (illegal),
        .end_of_code    (end_of_code)
    );

endmodule
